// File: sv/cop_pkg.sv
// ============================================================================
// cop_pkg - shared types and constants for the circular orbit position block
// Register map, CORDIC datapath widths, arctangent table and quadrant codes.
// ============================================================================
package cop_pkg;

    // Configuration register map
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_U_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_U_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_U_Z    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_V_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_V_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_V_Z    = 3'd7;

    // Field widths
    localparam int unsigned RADIUS_W = 24;
    localparam int unsigned RATE_W   = 32;
    localparam int unsigned BASIS_W  = 18;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ANGLE_W  = 32;
    localparam int unsigned POS_W    = 26;
    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values
    localparam logic [RADIUS_W-1:0]       RADIUS_RST = 24'd6878137;
    localparam logic [RATE_W-1:0]         RATE_RST   = 32'd251658240;
    localparam logic signed [BASIS_W-1:0] BASIS_ZERO = 18'sd0;
    localparam logic signed [BASIS_W-1:0] BASIS_ONE  = 18'sd65536;
    localparam logic signed [BASIS_W-1:0] BASIS_MONE = -18'sd65536;

    // Parameter defaults
    localparam int unsigned CORDIC_STAGES_DEF = 24;
    localparam int unsigned ANGLE_BITS_DEF    = 32;

    // CORDIC datapath: x/y in Q2.30 with headroom, z in angle units
    localparam int unsigned CW = 33;
    localparam int unsigned ZW = 32;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    // Coordinate pipeline depth and saturation limit
    localparam int unsigned COORD_LAT = 4;
    localparam int unsigned MW = 31;
    localparam logic signed [MW-1:0] POS_LIMIT = 31'sd33554431;

    // Quadrant codes taken from the top two angle bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           quad;
        logic [ANGLE_W-1:0]   angle;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    // Arctangent of 2^-i, quarter circle = 2^30, rounded to whole units
    function automatic logic signed [ZW-1:0] cop_atan(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            5'd24: v = 32'sd41;
            5'd25: v = 32'sd20;
            5'd26: v = 32'sd10;
            5'd27: v = 32'sd5;
            5'd28: v = 32'sd3;
            5'd29: v = 32'sd1;
            5'd30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/circular_orbit_position.sv
// ============================================================================
// circular_orbit_position - position on a circular orbit from elapsed time
// Rate multiply, CORDIC cell chain, quadrant fold and three coordinate units.
// ============================================================================
// Use:
//   Drive i_elapsed_days (Q16.16 days) and raise start; the item transfers on
//   any clock edge where start is high and busy is low. busy is high only
//   while reset is applied and on the first cycle after it, so one item may
//   transfer on every clock cycle.
//   Each item gives one result: o_valid is high for one cycle with
//   o_pos_x/y/z (metres, saturated) and o_orbit_angle. The receiver cannot
//   stall, so nothing is ever held back; results leave in input order.
//   Between transfer and result lie the rate-multiplier register, one register
//   per CORDIC cell (24 cells by default), the quadrant fold register and the
//   four stages of each coordinate unit.
//   Configuration registers are written through i_cfg_valid/o_cfg_ready with
//   a register index and data; write them only when no item is in flight.
//   Reset clears the pipeline valids and loads the default orbit set-up.
// ============================================================================
module circular_orbit_position
    import cop_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int unsigned ANGLE_BITS    = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [TIME_W-1:0]       i_elapsed_days,
    output logic                    o_valid,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic [ANGLE_W-1:0]      o_orbit_angle,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned LATENCY = CORDIC_STAGES + 2 + COORD_LAT;
    // Clear the angle bits below the kept precision
    localparam logic [ANGLE_W-1:0] ANGLE_MASK =
        ~((ANGLE_W'(1) << (ANGLE_W - ANGLE_BITS)) - ANGLE_W'(1));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0]       r_radius;
    logic [RATE_W-1:0]         r_rate;
    logic signed [BASIS_W-1:0] r_u_x, r_u_y, r_u_z;
    logic signed [BASIS_W-1:0] r_v_x, r_v_y, r_v_z;
    logic                      r_busy;
    logic                      w_cfg_wr;
    logic                      w_accept;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_accept    = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_radius <= RADIUS_RST;
            r_rate   <= RATE_RST;
            r_u_x    <= BASIS_ZERO;
            r_u_y    <= BASIS_ONE;
            r_u_z    <= BASIS_ZERO;
            r_v_x    <= BASIS_ONE;
            r_v_y    <= BASIS_ZERO;
            r_v_z    <= BASIS_MONE;
        end else begin
            r_busy <= 1'b0;
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    REG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                    REG_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                    REG_U_X:    r_u_x    <= i_cfg_data[BASIS_W-1:0];
                    REG_U_Y:    r_u_y    <= i_cfg_data[BASIS_W-1:0];
                    REG_U_Z:    r_u_z    <= i_cfg_data[BASIS_W-1:0];
                    REG_V_X:    r_v_x    <= i_cfg_data[BASIS_W-1:0];
                    REG_V_Y:    r_v_y    <= i_cfg_data[BASIS_W-1:0];
                    REG_V_Z:    r_v_z    <= i_cfg_data[BASIS_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Rate multiply: time (Q16.16) x rate (Q8.24) = Q24.40 revolutions.
    // Drop whole revolutions and keep bits 39..8 as the binary angle.
    // ------------------------------------------------------------------
    logic [2*TIME_W-1:0] w_prod;
    logic [ANGLE_W-1:0]  w_angle;
    t_cordic             r_head;
    t_cordic             n_head;

    assign w_prod  = (2*TIME_W)'(i_elapsed_days) * (2*TIME_W)'(r_rate);
    assign w_angle = w_prod[ANGLE_W+7:8] & ANGLE_MASK;

    always_comb begin
        n_head.valid = w_accept;
        n_head.angle = w_angle;
        n_head.quad  = w_angle[ANGLE_W-1:ANGLE_W-2];
        n_head.x     = CORDIC_GAIN;
        n_head.y     = '0;
        n_head.z     = ZW'(w_angle[ANGLE_W-3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head <= n_head;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain: one cell per rotation step, advance every cycle
    // ------------------------------------------------------------------
    t_cordic w_chain [0:CORDIC_STAGES];

    assign w_chain[0] = r_head;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        cop_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Quadrant fold: map the first-quadrant (cos, sin) to the full circle
    // ------------------------------------------------------------------
    t_cordic              w_tail;
    logic signed [CW-1:0] r_c, r_s;
    logic signed [CW-1:0] n_c, n_s;
    logic                 r_q_valid;
    logic [ANGLE_W-1:0]   r_q_angle;

    assign w_tail = w_chain[CORDIC_STAGES];

    always_comb begin
        case (w_tail.quad)
            QUAD_1: begin
                n_c = -w_tail.y;
                n_s = w_tail.x;
            end
            QUAD_2: begin
                n_c = -w_tail.x;
                n_s = -w_tail.y;
            end
            QUAD_3: begin
                n_c = w_tail.y;
                n_s = -w_tail.x;
            end
            default: begin
                n_c = w_tail.x;
                n_s = w_tail.y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else begin
            r_q_valid <= w_tail.valid;
        end
        r_c       <= n_c;
        r_s       <= n_s;
        r_q_angle <= w_tail.angle;
    end

    // ------------------------------------------------------------------
    // Coordinates: radius * (u*cos + v*sin), one unit per axis
    // ------------------------------------------------------------------
    cop_coord u_coord_x (
        .i_clk   (i_clk),
        .i_c     (r_c),
        .i_s     (r_s),
        .i_a     (r_u_x),
        .i_b     (r_v_x),
        .i_radius(r_radius),
        .o_pos   (o_pos_x)
    );

    cop_coord u_coord_y (
        .i_clk   (i_clk),
        .i_c     (r_c),
        .i_s     (r_s),
        .i_a     (r_u_y),
        .i_b     (r_v_y),
        .i_radius(r_radius),
        .o_pos   (o_pos_y)
    );

    cop_coord u_coord_z (
        .i_clk   (i_clk),
        .i_c     (r_c),
        .i_s     (r_s),
        .i_a     (r_u_z),
        .i_b     (r_v_z),
        .i_radius(r_radius),
        .o_pos   (o_pos_z)
    );

    // Hold the strobe and angle alongside the coordinate stages
    logic               r_vline [0:COORD_LAT-1];
    logic [ANGLE_W-1:0] r_aline [0:COORD_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COORD_LAT; k++) begin
                r_vline[k] <= 1'b0;
            end
        end else begin
            r_vline[0] <= r_q_valid;
            for (int k = 1; k < COORD_LAT; k++) begin
                r_vline[k] <= r_vline[k-1];
            end
        end
        r_aline[0] <= r_q_angle;
        for (int k = 1; k < COORD_LAT; k++) begin
            r_aline[k] <= r_aline[k-1];
        end
    end

    assign o_valid       = r_vline[COORD_LAT-1];
    assign o_orbit_angle = r_aline[COORD_LAT-1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_follows_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid
    ) else $error("transfer did not give a result after the pipeline latency");

    a_no_spurious_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY)
    ) else $error("result without a matching transfer");

    a_pos_saturated: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_x >= -POS_W'(POS_LIMIT)) && (o_pos_y >= -POS_W'(POS_LIMIT))
                    && (o_pos_z >= -POS_W'(POS_LIMIT))
    ) else $error("coordinate beyond the saturation limit");

    a_angle_masked: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_orbit_angle & ~ANGLE_MASK) == '0)
    ) else $error("orbit angle carries bits below the kept precision");

endmodule

// File: sv/cop_cordic_cell.sv
// ============================================================================
// cop_cordic_cell - one registered CORDIC rotation step
// Rotates x/y by the arctangent of 2^-STAGE towards zero residual angle.
// ============================================================================
module cop_cordic_cell
    import cop_pkg::*;
#(
    parameter int unsigned STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cordic i_cell,
    output t_cordic o_cell
);

    localparam logic signed [ZW-1:0] ATAN = cop_atan(5'(STAGE));

    t_cordic r_cell;
    t_cordic n_cell;

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;

    assign w_dx = i_cell.y >>> STAGE;
    assign w_dy = i_cell.x >>> STAGE;

    always_comb begin
        n_cell = i_cell;
        // Residual not negative: rotate forward, else back
        if (!i_cell.z[ZW-1]) begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.z = i_cell.z - ATAN;
        end else begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.z = i_cell.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// File: sv/cop_coord.sv
// ============================================================================
// cop_coord - one position coordinate from cosine, sine and basis vectors
// Four stages: products, rounded dot product, radius product, round/saturate.
// ============================================================================
module cop_coord
    import cop_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [CW-1:0]      i_c,
    input  logic signed [CW-1:0]      i_s,
    input  logic signed [BASIS_W-1:0] i_a,
    input  logic signed [BASIS_W-1:0] i_b,
    input  logic [RADIUS_W-1:0]       i_radius,
    output logic signed [POS_W-1:0]   o_pos
);

    localparam int unsigned PW = CW + BASIS_W;      // basis product
    localparam int unsigned SW = PW + 1;            // sum of two products
    localparam int unsigned DW = SW - 16;           // rounded dot, Q30
    localparam int unsigned RW = DW + RADIUS_W + 1; // radius product

    logic signed [PW-1:0]    r_pa;
    logic signed [PW-1:0]    r_pb;
    logic signed [DW-1:0]    r_dot;
    logic signed [RW-1:0]    r_prod;
    logic signed [POS_W-1:0] r_pos;

    logic signed [SW-1:0]    w_sum;
    logic signed [RW-1:0]    w_rnd;
    logic signed [MW-1:0]    w_m;
    logic signed [POS_W-1:0] n_pos;

    // Round Q46 to Q30 and Q30 to whole metres, flooring shifts
    assign w_sum = SW'(r_pa) + SW'(r_pb) + SW'(32768);
    assign w_rnd = r_prod + RW'(64'd536870912);
    assign w_m   = w_rnd[MW+29:30];

    always_comb begin
        if (w_m > POS_LIMIT) begin
            n_pos = POS_W'(POS_LIMIT);
        end else if (w_m < -POS_LIMIT) begin
            n_pos = POS_W'(-POS_LIMIT);
        end else begin
            n_pos = w_m[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= i_a * i_c;
        r_pb   <= i_b * i_s;
        r_dot  <= w_sum[SW-1:16];
        r_prod <= $signed({1'b0, i_radius}) * r_dot;
        r_pos  <= n_pos;
    end

    assign o_pos = r_pos;

endmodule
